[hdl/ryuv_pkg.sv]
// Shared types and constants for the RGB to planar YUV 4:2:0 converter.
// No dependencies; used by ryuv_matrix and rgb_to_yuv420_planar_converter.
`default_nettype none

package ryuv_pkg;

    // Widths fixed by the pixel and address formats.
    localparam int COMP_W   = 8;
    localparam int SIZE_W   = 13;
    localparam int LADDR_W  = 24;
    localparam int CADDR_W  = 22;
    localparam int CIDX_W   = 8;
    localparam int SUM_W    = 18;

    // Default frame limits and register reset values.
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 13'd352;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 13'd288;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    // BT.601 studio-range coefficients, scaled by 256.
    localparam logic signed [SUM_W-1:0] C_YR = 18'sd66;
    localparam logic signed [SUM_W-1:0] C_YG = 18'sd129;
    localparam logic signed [SUM_W-1:0] C_YB = 18'sd25;
    localparam logic signed [SUM_W-1:0] C_UR = -18'sd38;
    localparam logic signed [SUM_W-1:0] C_UG = -18'sd74;
    localparam logic signed [SUM_W-1:0] C_UB = 18'sd112;
    localparam logic signed [SUM_W-1:0] C_VR = 18'sd112;
    localparam logic signed [SUM_W-1:0] C_VG = -18'sd94;
    localparam logic signed [SUM_W-1:0] C_VB = -18'sd18;
    localparam logic signed [SUM_W-1:0] C_ROUND = 18'sd128;
    localparam logic [COMP_W-1:0] Y_OFFSET = 8'd16;
    localparam logic [COMP_W-1:0] C_OFFSET = 8'd128;

    typedef enum logic [1:0] {
        PLANE_NONE = 2'd0,
        PLANE_U    = 2'd1,
        PLANE_V    = 2'd2
    } chroma_plane_t;

    // Payload held between the input register and the result register.
    typedef struct packed {
        logic [COMP_W-1:0]  red;
        logic [COMP_W-1:0]  green;
        logic [COMP_W-1:0]  blue;
        logic [LADDR_W-1:0] luma_address;
        chroma_plane_t      chroma_plane;
        logic [CADDR_W-1:0] chroma_address;
        logic               frame_last;
    } pix_stage_t;

endpackage

`default_nettype wire

[hdl/rgb_to_yuv420_planar_converter.sv]
// RGB24 to planar YUV 4:2:0 converter, top level with position counters.
// Depends on ryuv_pkg and ryuv_matrix.
//
// One RGB pixel enters per beat on the s_ channel in raster order; each
// beat yields one result beat on the m_ channel with the Y sample and its
// luma address, plus a U sample (even row, even column) or a V sample (odd
// row, even column) with its index in that plane, selected by m_tuser.
// m_tlast marks the final pixel of the frame, after which all counters
// return to zero.
// Frame width and height are written through the cfg_ channel while the
// block is idle; zero acts as one and values above the limits saturate.
// An input register feeds the colour matrix, whose result lands in the
// output register. One pixel is accepted every cycle unless the receiver stalls.
// When the receiver stalls, the output register holds and the input
// register fills; s_tready then falls until m_tready returns.
// aresetn (synchronous) empties both registers, clears the counters and
// restores the frame size to 352 by 288.
`default_nettype none

module rgb_to_yuv420_planar_converter #(
    parameter int MAX_WIDTH  = ryuv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ryuv_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration writes.
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [ryuv_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [ryuv_pkg::SIZE_W-1:0] cfg_data,
    // Pixels in.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // Results out.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // luma[7:0], luma_address[31:8],
                                        // chroma[39:32], chroma_address[61:40], zero
    output logic [1:0]       m_tuser,   // chroma_plane[1:0]
    output logic             m_tlast    // frame_last
);

    localparam int SIZE_W  = ryuv_pkg::SIZE_W;
    localparam int COL_W   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [SIZE_W:0]   MAX_W_EXT = (SIZE_W+1)'(MAX_WIDTH);
    localparam logic [SIZE_W:0]   MAX_H_EXT = (SIZE_W+1)'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] W_LAST_MAX = SIZE_W'(MAX_WIDTH - 1);
    localparam logic [SIZE_W-1:0] H_LAST_MAX = SIZE_W'(MAX_HEIGHT - 1);

    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;

    logic [COL_W-1:0]             column_count_reg;
    logic [ROW_W-1:0]             row_count_reg;
    logic [ryuv_pkg::LADDR_W-1:0] pixel_count_reg;
    logic [ryuv_pkg::CADDR_W-1:0] u_count_reg;
    logic [ryuv_pkg::CADDR_W-1:0] v_count_reg;

    logic                 st_valid_reg;
    ryuv_pkg::pix_stage_t st_reg;
    ryuv_pkg::pix_stage_t st_next;

    logic                             out_valid_reg;
    logic [ryuv_pkg::COMP_W-1:0]      out_luma_reg;
    logic [ryuv_pkg::LADDR_W-1:0]     out_laddr_reg;
    logic [ryuv_pkg::COMP_W-1:0]      out_chroma_reg;
    ryuv_pkg::chroma_plane_t          out_plane_reg;
    logic [ryuv_pkg::CADDR_W-1:0]     out_caddr_reg;
    logic                             out_last_reg;
    logic [ryuv_pkg::COMP_W-1:0]      out_chroma_next;

    logic [SIZE_W-1:0] col_last_idx;
    logic [SIZE_W-1:0] row_last_idx;
    logic col_last;
    logic row_last;
    logic even_col;
    logic even_row;
    logic frame_last;
    logic in_accept;
    logic st_advance;

    logic [ryuv_pkg::COMP_W-1:0] mx_luma;
    logic [ryuv_pkg::COMP_W-1:0] mx_u;
    logic [ryuv_pkg::COMP_W-1:0] mx_v;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= ryuv_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= ryuv_pkg::RST_FRAME_HEIGHT;
        end else if (cfg_valid) begin
            case (cfg_index)
                ryuv_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                ryuv_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Last column and row indexes after the zero and oversize rules.
    always_comb begin
        if (frame_width_reg == '0) begin
            col_last_idx = '0;
        end else if ({1'b0, frame_width_reg} > MAX_W_EXT) begin
            col_last_idx = W_LAST_MAX;
        end else begin
            col_last_idx = frame_width_reg - SIZE_W'(1);
        end
        if (frame_height_reg == '0) begin
            row_last_idx = '0;
        end else if ({1'b0, frame_height_reg} > MAX_H_EXT) begin
            row_last_idx = H_LAST_MAX;
        end else begin
            row_last_idx = frame_height_reg - SIZE_W'(1);
        end
    end

    // ---------------- handshake ----------------
    assign st_advance = !out_valid_reg || m_tready;
    assign s_tready   = !st_valid_reg || st_advance;
    assign in_accept  = s_tvalid && s_tready;

    // ---------------- position counters ----------------
    assign col_last   = SIZE_W'(column_count_reg) >= col_last_idx;
    assign row_last   = SIZE_W'(row_count_reg) >= row_last_idx;
    assign even_col   = !column_count_reg[0];
    assign even_row   = !row_count_reg[0];
    assign frame_last = col_last && row_last;

    always_comb begin
        st_next.red            = s_tdata[7:0];
        st_next.green          = s_tdata[15:8];
        st_next.blue           = s_tdata[23:16];
        st_next.luma_address   = pixel_count_reg;
        st_next.frame_last     = frame_last;
        st_next.chroma_plane   = ryuv_pkg::PLANE_NONE;
        st_next.chroma_address = '0;
        if (even_col && even_row) begin
            st_next.chroma_plane   = ryuv_pkg::PLANE_U;
            st_next.chroma_address = u_count_reg;
        end else if (even_col) begin
            st_next.chroma_plane   = ryuv_pkg::PLANE_V;
            st_next.chroma_address = v_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            pixel_count_reg  <= '0;
            u_count_reg      <= '0;
            v_count_reg      <= '0;
        end else if (in_accept) begin
            if (frame_last) begin
                column_count_reg <= '0;
                row_count_reg    <= '0;
                pixel_count_reg  <= '0;
                u_count_reg      <= '0;
                v_count_reg      <= '0;
            end else begin
                pixel_count_reg <= pixel_count_reg + 1'b1;
                if (even_col && even_row) begin
                    u_count_reg <= u_count_reg + 1'b1;
                end else if (even_col) begin
                    v_count_reg <= v_count_reg + 1'b1;
                end
                if (col_last) begin
                    column_count_reg <= '0;
                    row_count_reg    <= row_count_reg + 1'b1;
                end else begin
                    column_count_reg <= column_count_reg + 1'b1;
                end
            end
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            st_reg <= st_next;
        end
    end

    // ---------------- colour matrix and result register ----------------
    ryuv_matrix u_matrix (
        .red     (st_reg.red),
        .green   (st_reg.green),
        .blue    (st_reg.blue),
        .luma    (mx_luma),
        .u_value (mx_u),
        .v_value (mx_v)
    );

    always_comb begin
        case (st_reg.chroma_plane)
            ryuv_pkg::PLANE_U: out_chroma_next = mx_u;
            ryuv_pkg::PLANE_V: out_chroma_next = mx_v;
            default:           out_chroma_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (st_advance) begin
            out_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_advance && st_valid_reg) begin
            out_luma_reg   <= mx_luma;
            out_laddr_reg  <= st_reg.luma_address;
            out_chroma_reg <= out_chroma_next;
            out_plane_reg  <= st_reg.chroma_plane;
            out_caddr_reg  <= st_reg.chroma_address;
            out_last_reg   <= st_reg.frame_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_caddr_reg, out_chroma_reg, out_laddr_reg, out_luma_reg};
    assign m_tuser  = out_plane_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[hdl/ryuv_matrix.sv]
// Colour matrix: BT.601 RGB to Y, U and V with rounding and offsets.
// Depends on ryuv_pkg for coefficients and widths.
`default_nettype none

module ryuv_matrix (
    input  wire logic [ryuv_pkg::COMP_W-1:0] red,
    input  wire logic [ryuv_pkg::COMP_W-1:0] green,
    input  wire logic [ryuv_pkg::COMP_W-1:0] blue,
    output logic      [ryuv_pkg::COMP_W-1:0] luma,
    output logic      [ryuv_pkg::COMP_W-1:0] u_value,
    output logic      [ryuv_pkg::COMP_W-1:0] v_value
);

    localparam int PAD_W = ryuv_pkg::SUM_W - ryuv_pkg::COMP_W;

    logic signed [ryuv_pkg::SUM_W-1:0] r_s;
    logic signed [ryuv_pkg::SUM_W-1:0] g_s;
    logic signed [ryuv_pkg::SUM_W-1:0] b_s;
    logic signed [ryuv_pkg::SUM_W-1:0] y_sum;
    logic signed [ryuv_pkg::SUM_W-1:0] u_sum;
    logic signed [ryuv_pkg::SUM_W-1:0] v_sum;

    assign r_s = signed'({{PAD_W{1'b0}}, red});
    assign g_s = signed'({{PAD_W{1'b0}}, green});
    assign b_s = signed'({{PAD_W{1'b0}}, blue});

    assign y_sum = ryuv_pkg::C_YR * r_s + ryuv_pkg::C_YG * g_s + ryuv_pkg::C_YB * b_s
                 + ryuv_pkg::C_ROUND;
    assign u_sum = ryuv_pkg::C_UR * r_s + ryuv_pkg::C_UG * g_s + ryuv_pkg::C_UB * b_s
                 + ryuv_pkg::C_ROUND;
    assign v_sum = ryuv_pkg::C_VR * r_s + ryuv_pkg::C_VG * g_s + ryuv_pkg::C_VB * b_s
                 + ryuv_pkg::C_ROUND;

    // Bits 15:8 of the two's complement sum are the floor shift, modulo 256.
    assign luma    = y_sum[15:8] + ryuv_pkg::Y_OFFSET;
    assign u_value = u_sum[15:8] + ryuv_pkg::C_OFFSET;
    assign v_value = v_sum[15:8] + ryuv_pkg::C_OFFSET;

endmodule

`default_nettype wire
